@@ rtl/med5_pkg.sv @@
package med5_pkg;

    // Sample width and window size
    localparam int SAMPLE_BITS  = 16;
    localparam int WINDOW_WIDTH = 5;
    localparam int MAX_RESULTS  = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [1:0]                    t_count;

    // Fill states of the series history
    localparam t_count SEEN_NONE = 2'd0;
    localparam t_count SEEN_ONE  = 2'd1;
    localparam t_count SEEN_FULL = 2'd2;

    // Median of five by elimination: drop two values that each have
    // three larger companions, then the smallest survivor is the median.
    function automatic t_sample median5(input t_sample a, input t_sample b,
                                        input t_sample c, input t_sample d,
                                        input t_sample e);
        t_sample p_lo, p_hi, q_lo, q_hi;
        t_sample u, v_lo, v_hi, r_lo, r_hi;
        t_sample res;
        // sort the two pairs
        p_lo = (a <= b) ? a : b;
        p_hi = (a <= b) ? b : a;
        q_lo = (c <= d) ? c : d;
        q_hi = (c <= d) ? d : c;
        // drop the lower of the two pair minimums
        if (p_lo <= q_lo) begin
            u    = p_hi;
            v_lo = q_lo;
            v_hi = q_hi;
        end else begin
            u    = q_hi;
            v_lo = p_lo;
            v_hi = p_hi;
        end
        // pair the survivor with the fifth value and drop again
        r_lo = (u <= e) ? u : e;
        r_hi = (u <= e) ? e : u;
        if (r_lo <= v_lo) begin
            res = (r_hi <= v_lo) ? r_hi : v_lo;
        end else begin
            res = (r_lo <= v_hi) ? r_lo : v_hi;
        end
        return res;
    endfunction

endpackage

@@ rtl/median5_filter_mirrored_edges.sv @@
// Latency: a result is valid in the cycle after its input transaction.
// Throughput: one sample per cycle while each sample yields at most one median
// and the output is not stalled; a last sample that flushes two or three medians
// holds input ready low while the three-entry result queue drains.
// Reset (synchronous, active low) empties the queue and starts a new series.
module median5_filter_mirrored_edges (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  med5_pkg::t_sample            i_sample,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output med5_pkg::t_sample            o_median,
    output logic                         o_last_out
);

    med5_pkg::t_sample r_hist [4];
    med5_pkg::t_sample n_hist [4];
    med5_pkg::t_count  r_seen;
    med5_pkg::t_count  n_seen;

    med5_pkg::t_sample r_q_med  [med5_pkg::MAX_RESULTS];
    logic              r_q_last [med5_pkg::MAX_RESULTS];
    med5_pkg::t_count  r_q_cnt;

    med5_pkg::t_sample res_med  [med5_pkg::MAX_RESULTS];
    logic              res_last [med5_pkg::MAX_RESULTS];
    med5_pkg::t_count  res_cnt;

    med5_pkg::t_sample f1, f2, f3;
    med5_pkg::t_sample med_mid, med_end1, med_end2;
    logic              full;
    logic              accept, pop;

    // Handshakes: take a new sample when the queue will be empty next cycle
    assign pop     = (r_q_cnt != 2'd0) && i_ready;
    assign o_ready = (r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_q_cnt != 2'd0);
    assign o_median   = r_q_med[0];
    assign o_last_out = r_q_last[0];

    // Counter codes above full act as full
    assign full = (r_seen != med5_pkg::SEEN_NONE) && (r_seen != med5_pkg::SEEN_ONE);

    // Flush window taps: second sample sees the mirrored start s1,s0,s0
    assign f1 = full ? r_hist[1] : i_sample;
    assign f2 = full ? r_hist[2] : r_hist[3];
    assign f3 = r_hist[3];

    // Three median networks working in parallel
    assign med_mid  = med5_pkg::median5(r_hist[0], r_hist[1], r_hist[2], r_hist[3], i_sample);
    assign med_end1 = med5_pkg::median5(f1, f2, f3, i_sample, i_sample);
    assign med_end2 = med5_pkg::median5(f2, f3, i_sample, i_sample, f3);

    // Results and next history for the offered sample
    always_comb begin
        n_hist = r_hist;
        n_seen = r_seen;
        res_cnt = 2'd0;
        for (int k = 0; k < med5_pkg::MAX_RESULTS; k++) begin
            res_med[k]  = med_end2;
            res_last[k] = 1'b0;
        end
        if (r_seen == med5_pkg::SEEN_NONE) begin
            if (i_last) begin
                // single-sample series passes through
                res_cnt     = 2'd1;
                res_med[0]  = i_sample;
                res_last[0] = 1'b1;
            end else begin
                n_hist[3] = i_sample;
                n_seen    = med5_pkg::SEEN_ONE;
            end
        end else if (r_seen == med5_pkg::SEEN_ONE) begin
            if (i_last) begin
                res_cnt     = 2'd2;
                res_med[0]  = med_end1;
                res_med[1]  = med_end2;
                res_last[1] = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    n_hist[k] = '0;
                end
                n_seen = med5_pkg::SEEN_NONE;
            end else begin
                // mirrored start: s1,s0,s0,s1
                n_hist[0] = i_sample;
                n_hist[1] = r_hist[3];
                n_hist[2] = r_hist[3];
                n_hist[3] = i_sample;
                n_seen    = med5_pkg::SEEN_FULL;
            end
        end else begin
            res_med[0] = med_mid;
            if (i_last) begin
                res_cnt     = 2'd3;
                res_med[1]  = med_end1;
                res_med[2]  = med_end2;
                res_last[2] = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    n_hist[k] = '0;
                end
                n_seen = med5_pkg::SEEN_NONE;
            end else begin
                res_cnt   = 2'd1;
                n_hist[0] = r_hist[1];
                n_hist[1] = r_hist[2];
                n_hist[2] = r_hist[3];
                n_hist[3] = i_sample;
            end
        end
    end

    // Series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= med5_pkg::SEEN_NONE;
            for (int k = 0; k < 4; k++) begin
                r_hist[k] <= '0;
            end
        end else if (accept) begin
            r_seen <= n_seen;
            r_hist <= n_hist;
        end
    end

    // Result queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= 2'd0;
        end else if (accept && (res_cnt != 2'd0)) begin
            r_q_cnt <= res_cnt;
        end else if (pop) begin
            r_q_cnt <= r_q_cnt - 2'd1;
        end
    end

    // Result queue payload, head at entry zero
    always_ff @(posedge i_clk) begin
        if (accept && (res_cnt != 2'd0)) begin
            r_q_med  <= res_med;
            r_q_last <= res_last;
        end else if (pop) begin
            for (int k = 0; k < med5_pkg::MAX_RESULTS - 1; k++) begin
                r_q_med[k]  <= r_q_med[k+1];
                r_q_last[k] <= r_q_last[k+1];
            end
        end
    end

endmodule
